FILE: rtl/usdt_pkg.sv
// ----------------------------------------------------------------------------
// UDP socket demultiplexer table: shared types and constants
// Operation and status codes, the broadcast command bus and the token that
// travels along the row of socket cells.
// ----------------------------------------------------------------------------
package usdt_pkg;

    localparam logic [1:0] OP_RECV    = 2'd0;
    localparam logic [1:0] OP_CONNECT = 2'd1;
    localparam logic [1:0] OP_LISTEN  = 2'd2;
    localparam logic [1:0] OP_CLOSE   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_NOMATCH    = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

    localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
    localparam logic [15:0] FIRST_AUTO_PORT = 16'd1024;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_RECV,
        CMD_CONNECT,
        CMD_LISTEN,
        CMD_CLOSE
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] peer_ip;
        logic [15:0] target_port;
        logic [3:0]  close_handle;
        logic [31:0] host_ip;
        logic [15:0] auto_port;
    } t_bus;

    typedef struct packed {
        logic active;
        logic found;
    } t_token;

endpackage

FILE: rtl/udp_socket_demux_table_core.sv
// ----------------------------------------------------------------------------
// UDP socket demultiplexer table: top level
// Receive lookup, connect, listen and close on a row of socket cells.
//
// Channel   Dir  tdata (low bit up)                                 tuser
// s_axis    in   src_ip, dst_ip, source port, destination port,     operation
//                packet_length, peer_ip, target_port, close_handle
//                (168 bits)
// m_axis    out  handle, payload_length, assigned_port (40 bits)     status
// cfg       in   i_cfg_wdata = host_ip, written when i_cfg_we is high
//
// One transaction is worked on at a time, from acceptance to the next
// acceptance: a token walks the cell row one cell per cycle, then the result
// is captured and loaded into the output register.
// The result is loaded once the output register is free, so it waits while the
// previous result is still stalled.
// Reset is synchronous and clears the table and sets the port counter to 1024.
// ----------------------------------------------------------------------------
module udp_socket_demux_table_core #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // src_ip, dst_ip, source port, destination port, packet_length, peer_ip,
    // target_port, close_handle, zero padding
    input  logic [167:0] s_axis_tdata,
    // operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // handle, payload_length, assigned_port, zero padding
    output logic [39:0]  m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned HND_W = (IDX_W > 4) ? IDX_W : 4;

    usdt_pkg::t_state r_state;
    usdt_pkg::t_state n_state;
    usdt_pkg::t_bus   r_bus;
    usdt_pkg::t_bus   w_bus;
    logic [31:0]      r_host_ip;
    logic [15:0]      r_next_port;
    logic [15:0]      r_plen;
    logic             r_inject;
    logic             r_found;
    logic [IDX_W-1:0] r_hnd;
    logic             r_out_valid;
    logic [2:0]       r_out_status;
    logic [3:0]       r_out_handle;
    logic [15:0]      r_out_payload;
    logic [15:0]      r_out_aport;

    usdt_pkg::t_token w_tok [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] w_hnd [TABLE_ENTRIES+1];

    logic             w_accept;
    logic             w_out_free;
    logic             w_load_out;
    logic             w_return;
    usdt_pkg::t_cmd   w_cmd_in;
    logic [15:0]      w_plen_in;
    logic [HND_W-1:0] w_hnd_ext;
    logic [2:0]       w_res_status;
    logic [3:0]       w_res_handle;
    logic [15:0]      w_res_payload;
    logic [15:0]      w_res_aport;
    logic             w_bump_port;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_return   = w_tok[TABLE_ENTRIES].active;
    assign w_plen_in  = s_axis_tdata[111:96];

    always_comb begin
        unique case (s_axis_tuser)
            usdt_pkg::OP_RECV: begin
                w_cmd_in = (w_plen_in < usdt_pkg::UDP_HDR_BYTES) ? usdt_pkg::CMD_NONE
                                                                  : usdt_pkg::CMD_RECV;
            end
            usdt_pkg::OP_CONNECT: w_cmd_in = usdt_pkg::CMD_CONNECT;
            usdt_pkg::OP_LISTEN:  w_cmd_in = usdt_pkg::CMD_LISTEN;
            usdt_pkg::OP_CLOSE:   w_cmd_in = usdt_pkg::CMD_CLOSE;
            default:              w_cmd_in = usdt_pkg::CMD_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            usdt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = usdt_pkg::S_BUSY;
                end
            end
            usdt_pkg::S_BUSY: begin
                if (w_return) begin
                    n_state = usdt_pkg::S_DONE;
                end
            end
            usdt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = usdt_pkg::S_IDLE;
                end
            end
            default: n_state = usdt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == usdt_pkg::S_IDLE);
        w_load_out    = (r_state == usdt_pkg::S_DONE) && w_out_free;
    end

    always_comb begin
        w_bus           = r_bus;
        w_bus.host_ip   = r_host_ip;
        w_bus.auto_port = r_next_port;
    end

    assign w_tok[0] = '{active: r_inject, found: 1'b0};
    assign w_hnd[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        usdt_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .CELL_INDEX    (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_bus    (w_bus),
            .i_tok    (w_tok[g]),
            .i_handle (w_hnd[g]),
            .o_tok    (w_tok[g+1]),
            .o_handle (w_hnd[g+1])
        );
    end

    assign w_hnd_ext = HND_W'(r_hnd);

    always_comb begin
        w_res_status  = usdt_pkg::ST_OK;
        w_res_handle  = r_found ? w_hnd_ext[3:0] : 4'd0;
        w_res_payload = 16'd0;
        w_res_aport   = 16'd0;
        w_bump_port   = 1'b0;
        unique case (r_bus.cmd)
            usdt_pkg::CMD_NONE: begin
                w_res_status = usdt_pkg::ST_SHORT;
            end
            usdt_pkg::CMD_RECV: begin
                w_res_status  = r_found ? usdt_pkg::ST_OK : usdt_pkg::ST_NOMATCH;
                w_res_payload = r_found ? (r_plen - usdt_pkg::UDP_HDR_BYTES) : 16'd0;
            end
            usdt_pkg::CMD_CONNECT: begin
                w_res_status = r_found ? usdt_pkg::ST_OK : usdt_pkg::ST_FULL;
                w_res_aport  = r_found ? r_next_port : 16'd0;
                w_bump_port  = r_found;
            end
            usdt_pkg::CMD_LISTEN: begin
                w_res_status = r_found ? usdt_pkg::ST_OK : usdt_pkg::ST_FULL;
                w_res_aport  = r_found ? r_bus.target_port : 16'd0;
            end
            usdt_pkg::CMD_CLOSE: begin
                w_res_status = r_found ? usdt_pkg::ST_OK : usdt_pkg::ST_BAD_HANDLE;
                w_res_handle = r_bus.close_handle;
            end
            default: begin
                w_res_status = usdt_pkg::ST_SHORT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= usdt_pkg::S_IDLE;
            r_host_ip   <= 32'd0;
            r_next_port <= usdt_pkg::FIRST_AUTO_PORT;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= w_accept;
            if (i_cfg_we) begin
                r_host_ip <= i_cfg_wdata;
            end
            if (w_load_out && w_bump_port) begin
                r_next_port <= r_next_port + 16'd1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bus.cmd          <= w_cmd_in;
            r_bus.src_ip       <= s_axis_tdata[31:0];
            r_bus.dst_ip       <= s_axis_tdata[63:32];
            r_bus.sport        <= s_axis_tdata[79:64];
            r_bus.dport        <= s_axis_tdata[95:80];
            r_plen             <= w_plen_in;
            r_bus.peer_ip      <= s_axis_tdata[143:112];
            r_bus.target_port  <= s_axis_tdata[159:144];
            r_bus.close_handle <= s_axis_tdata[163:160];
            r_bus.host_ip      <= 32'd0;
            r_bus.auto_port    <= 16'd0;
        end
        if (w_return) begin
            r_found <= w_tok[TABLE_ENTRIES].found;
            r_hnd   <= w_hnd[TABLE_ENTRIES];
        end
        if (w_load_out) begin
            r_out_status  <= w_res_status;
            r_out_handle  <= w_res_handle;
            r_out_payload <= w_res_payload;
            r_out_aport   <= w_res_aport;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'd0, r_out_aport, r_out_payload, r_out_handle};

endmodule

FILE: rtl/usdt_cell.sv
// ----------------------------------------------------------------------------
// UDP socket demultiplexer table: socket cell
// Holds one table entry. A token passes through once per transaction; the
// first cell that can serve the command claims it and updates its entry.
// ----------------------------------------------------------------------------
module usdt_cell #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned CELL_INDEX    = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  usdt_pkg::t_bus                   i_bus,
    input  usdt_pkg::t_token                 i_tok,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_handle,
    output usdt_pkg::t_token                 o_tok,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_handle
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CMP_W = (IDX_W > 4) ? IDX_W : 4;

    logic             r_valid;
    logic             r_listen;
    logic [31:0]      r_lip;
    logic [15:0]      r_lport;
    logic [31:0]      r_rip;
    logic [15:0]      r_rport;
    usdt_pkg::t_token r_tok;
    logic [IDX_W-1:0] r_handle;

    logic             n_valid;
    logic             n_listen;
    logic [31:0]      n_rip;
    logic [15:0]      n_rport;

    logic             w_live;
    logic             w_hit_recv;
    logic             w_hit_open;
    logic             w_hit_close;
    logic             w_hit;
    logic             w_connect;
    logic [CMP_W-1:0] w_ch;
    logic [CMP_W-1:0] w_me;

    assign w_live    = i_tok.active && !i_tok.found;
    assign w_connect = (i_bus.cmd == usdt_pkg::CMD_CONNECT);
    assign w_ch      = CMP_W'(i_bus.close_handle);
    assign w_me      = CMP_W'(CELL_INDEX);

    assign w_hit_recv = w_live && (i_bus.cmd == usdt_pkg::CMD_RECV) && r_valid
                        && (r_lip == i_bus.dst_ip) && (r_lport == i_bus.dport)
                        && (((r_rip == i_bus.src_ip) && (r_rport == i_bus.sport))
                            || r_listen);
    assign w_hit_open = w_live && !r_valid
                        && ((i_bus.cmd == usdt_pkg::CMD_CONNECT)
                            || (i_bus.cmd == usdt_pkg::CMD_LISTEN));
    assign w_hit_close = w_live && (i_bus.cmd == usdt_pkg::CMD_CLOSE) && r_valid
                         && (w_ch == w_me);
    assign w_hit = w_hit_recv || w_hit_open || w_hit_close;

    always_comb begin
        n_valid  = r_valid;
        n_listen = r_listen;
        n_rip    = r_rip;
        n_rport  = r_rport;
        if (w_hit_recv && r_listen) begin
            n_rip   = i_bus.src_ip;
            n_rport = i_bus.sport;
        end
        if (w_hit_open) begin
            n_valid  = 1'b1;
            n_listen = !w_connect;
            n_rip    = w_connect ? i_bus.peer_ip : 32'd0;
            n_rport  = w_connect ? i_bus.target_port : 16'd0;
        end
        if (w_hit_close) begin
            n_valid  = 1'b0;
            n_listen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_listen <= 1'b0;
            r_tok    <= '0;
        end else begin
            r_valid      <= n_valid;
            r_listen     <= n_listen;
            r_tok.active <= i_tok.active;
            r_tok.found  <= i_tok.found || w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rip    <= n_rip;
        r_rport  <= n_rport;
        r_handle <= w_hit ? IDX_W'(CELL_INDEX) : i_handle;
        if (w_hit_open) begin
            r_lip   <= i_bus.host_ip;
            r_lport <= w_connect ? i_bus.auto_port : i_bus.target_port;
        end
    end

    assign o_tok    = r_tok;
    assign o_handle = r_handle;

endmodule

FILE: rtl/usdt_checker.sv
// ----------------------------------------------------------------------------
// UDP socket demultiplexer table: port checker
// Concurrent assertions on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module usdt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    logic w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // One transaction is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("input accepted while a transaction was in progress");

    // No result can appear in the cycle after an acceptance.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(m_axis_tvalid))
        else $error("result presented too early after acceptance");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= usdt_pkg::ST_BAD_HANDLE))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind udp_socket_demux_table_core usdt_checker u_usdt_checker (.*);
